[design/wsc_pkg.sv]
// Shared constants, codes and tables of the waypoint steering controller.
package wsc_pkg;

    localparam int WAYPOINTS = 8;
    localparam int IDX_W     = $clog2(WAYPOINTS);
    localparam int CNT_W     = 4;
    localparam int ADDR_W    = 5;
    localparam int CW        = 45;
    localparam int ZW        = 24;
    localparam int AW        = 44;
    localparam int MW        = 22;

    localparam logic signed [ZW-1:0] ANG_PI      = 24'sd205887;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 24'sd102944;
    localparam logic signed [ZW-1:0] ANG_TWO_PI  = 24'sd411775;
    localparam logic [4:0]           LAST_STEP   = 5'd16;
    localparam logic signed [CW-1:0] GAIN_INV    = 45'sd39797;
    localparam logic signed [CW-1:0] NORM_LIMIT  = 45'sd1099511627776;

    localparam logic [1:0] MODE_POSE = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_LOAD = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    localparam logic [1:0] PH_APPROACH = 2'd0;
    localparam logic [1:0] PH_TURN     = 2'd1;
    localparam logic [1:0] PH_REACHED  = 2'd2;
    localparam logic [1:0] PH_DONE     = 2'd3;

    localparam logic [2:0] REG_DTOL  = 3'd0;
    localparam logic [2:0] REG_ATOL  = 3'd1;
    localparam logic [2:0] REG_OFSX  = 3'd2;
    localparam logic [2:0] REG_OFSY  = 3'd3;
    localparam logic [2:0] REG_GAIN  = 3'd4;
    localparam logic [2:0] REG_WCNT  = 3'd5;

    localparam logic [1:0] MOP_QUAT = 2'd0;
    localparam logic [1:0] MOP_ROT  = 2'd1;
    localparam logic [1:0] MOP_DIST = 2'd2;
    localparam logic [1:0] MOP_TURN = 2'd3;

    function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 24'sd51472;
            5'd1:    v = 24'sd30386;
            5'd2:    v = 24'sd16055;
            5'd3:    v = 24'sd8150;
            5'd4:    v = 24'sd4091;
            5'd5:    v = 24'sd2047;
            5'd6:    v = 24'sd1024;
            5'd7:    v = 24'sd512;
            5'd8:    v = 24'sd256;
            5'd9:    v = 24'sd128;
            5'd10:   v = 24'sd64;
            5'd11:   v = 24'sd32;
            5'd12:   v = 24'sd16;
            5'd13:   v = 24'sd8;
            5'd14:   v = 24'sd4;
            5'd15:   v = 24'sd2;
            5'd16:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

[design/wsc_cmd_if.sv]
// Command and result channel interfaces of the waypoint steering controller.
interface wsc_cmd_if;
    import wsc_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [17:0] quat_x;
    logic signed [17:0] quat_y;
    logic signed [17:0] quat_z;
    logic signed [17:0] quat_w;
    logic [IDX_W-1:0]   wp_slot;
    logic signed [31:0] wp_x;
    logic signed [31:0] wp_y;
    logic signed [19:0] wp_heading;
    modport source (output valid, mode, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    wp_slot, wp_x, wp_y, wp_heading, input ready);
    modport sink (input valid, mode, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  wp_slot, wp_x, wp_y, wp_heading, output ready);
endinterface

interface wsc_res_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] left_drive;
    logic signed [14:0] right_drive;
    logic [3:0]         target_index;
    logic [1:0]         phase;
    modport source (output valid, left_drive, right_drive, target_index, phase, input ready);
    modport sink (input valid, left_drive, right_drive, target_index, phase, output ready);
endinterface

[design/waypoint_steering_controller_core.sv]
// Throughput: one transaction at a time; the shared CORDIC shift-add unit and the
// shared 22x22 multiplier set the pace (17 CORDIC steps plus up to 40 prenormalize
// steps per atan2, one product per cycle).
// Reset: synchronous active low; clears the pose, target index, result valid and
// loads the configuration defaults. The waypoint table is not cleared.
module waypoint_steering_controller_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    wsc_cmd_if.sink                  i_cmd,
    wsc_res_if.source                o_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [wsc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import wsc_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_MUL      = 5'd1;
    localparam logic [4:0] S_AT_INIT  = 5'd2;
    localparam logic [4:0] S_AT_NORM  = 5'd3;
    localparam logic [4:0] S_AT_ITER  = 5'd4;
    localparam logic [4:0] S_SC_INIT  = 5'd5;
    localparam logic [4:0] S_SC_ITER  = 5'd6;
    localparam logic [4:0] S_SC_DONE  = 5'd7;
    localparam logic [4:0] S_P_YAW    = 5'd8;
    localparam logic [4:0] S_P_HEAD   = 5'd9;
    localparam logic [4:0] S_P_FIN    = 5'd10;
    localparam logic [4:0] S_T_CHK    = 5'd11;
    localparam logic [4:0] S_T_RD     = 5'd12;
    localparam logic [4:0] S_T_D      = 5'd13;
    localparam logic [4:0] S_T_D2     = 5'd14;
    localparam logic [4:0] S_T_DIST   = 5'd15;
    localparam logic [4:0] S_T_FAR    = 5'd16;
    localparam logic [4:0] S_NORM     = 5'd17;
    localparam logic [4:0] S_T_ST1    = 5'd18;
    localparam logic [4:0] S_T_ST2    = 5'd19;
    localparam logic [4:0] S_T_TURN   = 5'd20;
    localparam logic [4:0] S_T_TFIN   = 5'd21;
    localparam logic [4:0] S_OUT      = 5'd22;

    localparam logic signed [27:0] STEER_BASE = 28'sd3276800;
    localparam logic signed [27:0] STEER_LIM  = 28'sd3932160;
    localparam logic signed [AW-1:0] TURN_LIM = 44'sd671088640;
    localparam logic signed [AW-1:0] HALF_Q16 = 44'sd32768;

    logic [4:0]           r_state;
    logic [1:0]           r_mode;
    logic [1:0]           r_mop;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_near;
    logic                 r_flip;
    logic [4:0]           r_i;

    logic [16:0]          r_dtol;
    logic [17:0]          r_atol;
    logic signed [17:0]   r_ox;
    logic signed [17:0]   r_oy;
    logic [15:0]          r_gain;
    logic [3:0]           r_wcnt;

    logic signed [31:0]   r_rx;
    logic signed [31:0]   r_ry;
    logic signed [19:0]   r_rh;
    logic [3:0]           r_idx;

    logic signed [31:0]   r_px;
    logic signed [31:0]   r_py;
    logic signed [17:0]   r_qx, r_qy, r_qz, r_qw;

    logic signed [31:0]   tab_x [WAYPOINTS];
    logic signed [31:0]   tab_y [WAYPOINTS];
    logic signed [19:0]   tab_h [WAYPOINTS];
    logic signed [31:0]   r_tx, r_ty;
    logic signed [19:0]   r_th;

    logic signed [32:0]   r_dx, r_dy;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic signed [ZW-1:0] r_e;
    logic signed [17:0]   r_c, r_s;

    logic signed [AW-1:0] r_acc [4];
    logic signed [AW-1:0] r_prod;
    logic [1:0]           r_pdst;
    logic                 r_pneg;
    logic                 r_pvld;

    logic signed [14:0]   r_l, r_r;
    logic [1:0]           r_ph;
    logic                 r_ov;
    logic signed [14:0]   r_ol, r_or;
    logic [3:0]           r_oi;
    logic [1:0]           r_oph;

    logic                 cmd_acc;
    logic                 cfg_wr;
    logic signed [MW-1:0] m_a, m_b;
    logic [1:0]           m_dst;
    logic                 m_neg;
    logic [CNT_W-1:0]     m_last;
    logic signed [CW-1:0] xs, ys;
    logic signed [AW-1:0] p_num, p_den, p_mag, p_lock, p_lock_abs;
    logic signed [AW-1:0] pf_rs0, pf_rs1, pf_x, pf_y;
    logic signed [ZW-1:0] sc_th, sc_t1;
    logic [3:0]           cnt_eff;
    logic signed [32:0]   dx_abs, dy_abs;
    logic signed [27:0]   st_p, st_l, st_r, st_lc, st_rc, st_lr, st_rr;
    logic signed [AW-1:0] tf_t, tf_r;
    logic signed [ZW-1:0] e_abs;

    assign cmd_acc     = i_cmd.valid && (r_state == S_IDLE);
    assign i_cmd.ready = (r_state == S_IDLE);
    assign cfg_wr      = psel && penable && pwrite;
    assign pready      = 1'b1;

    assign o_res.valid        = r_ov;
    assign o_res.left_drive   = r_ol;
    assign o_res.right_drive  = r_or;
    assign o_res.target_index = r_oi;
    assign o_res.phase        = r_oph;

    always_comb begin
        unique case (paddr[4:2])
            REG_DTOL: prdata = {15'd0, r_dtol};
            REG_ATOL: prdata = {14'd0, r_atol};
            REG_OFSX: prdata = {14'd0, r_ox};
            REG_OFSY: prdata = {14'd0, r_oy};
            REG_GAIN: prdata = {16'd0, r_gain};
            REG_WCNT: prdata = {28'd0, r_wcnt};
            default:  prdata = 32'd0;
        endcase
    end

    always_comb begin
        m_a    = '0;
        m_b    = '0;
        m_dst  = 2'd0;
        m_neg  = 1'b0;
        m_last = 4'd1;
        unique case (r_mop)
            MOP_QUAT: begin
                m_last = 4'd8;
                case (r_cnt)
                    4'd0:    begin m_a = MW'(r_qx); m_b = MW'(r_qy); end
                    4'd1:    begin m_a = MW'(r_qw); m_b = MW'(r_qz); end
                    4'd2:    begin m_a = MW'(r_qw); m_b = MW'(r_qw); m_dst = 2'd1; end
                    4'd3:    begin m_a = MW'(r_qx); m_b = MW'(r_qx); m_dst = 2'd1; end
                    4'd4:    begin m_a = MW'(r_qy); m_b = MW'(r_qy); m_dst = 2'd2; end
                    4'd5:    begin m_a = MW'(r_qz); m_b = MW'(r_qz); m_dst = 2'd2; end
                    4'd6:    begin m_a = MW'(r_qx); m_b = MW'(r_qz); m_dst = 2'd3; end
                    default: begin
                        m_a = MW'(r_qw); m_b = MW'(r_qy); m_dst = 2'd3; m_neg = 1'b1;
                    end
                endcase
            end
            MOP_ROT: begin
                m_last = 4'd4;
                case (r_cnt)
                    4'd0:    begin m_a = MW'(r_ox); m_b = MW'(r_c); end
                    4'd1:    begin m_a = MW'(r_oy); m_b = MW'(r_s); end
                    4'd2:    begin m_a = MW'(r_ox); m_b = MW'(r_s); m_dst = 2'd1; end
                    default: begin
                        m_a = MW'(r_oy); m_b = MW'(r_c); m_dst = 2'd1; m_neg = 1'b1;
                    end
                endcase
            end
            MOP_DIST: begin
                m_last = 4'd3;
                case (r_cnt)
                    4'd0:    begin m_a = r_dx[MW-1:0]; m_b = r_dx[MW-1:0]; end
                    4'd1:    begin m_a = r_dy[MW-1:0]; m_b = r_dy[MW-1:0]; end
                    default: begin
                        m_a = {5'd0, r_dtol}; m_b = {5'd0, r_dtol}; m_dst = 2'd1;
                    end
                endcase
            end
            MOP_TURN: begin
                m_last = 4'd1;
                m_a    = r_e[MW-1:0];
                m_b    = {6'd0, r_gain};
            end
            default: m_last = 4'd1;
        endcase
    end

    always_comb begin
        xs         = r_cx >>> r_i;
        ys         = r_cy >>> r_i;
        p_num      = r_acc[0] <<< 1;
        p_den      = r_acc[1] - r_acc[2];
        p_mag      = r_acc[1] + r_acc[2];
        p_lock     = r_acc[3] <<< 1;
        p_lock_abs = (p_lock < 0) ? -p_lock : p_lock;
        pf_rs0     = (r_acc[0] + HALF_Q16) >>> 16;
        pf_rs1     = (r_acc[1] + HALF_Q16) >>> 16;
        pf_x       = AW'(r_ox) - AW'(r_py) - pf_rs0;
        pf_y       = pf_rs1 - (AW'(r_px) - AW'(r_oy));
        sc_th      = ZW'(r_rh);
        if (sc_th > ANG_PI) begin
            sc_t1 = sc_th - ANG_TWO_PI;
        end else if (sc_th < -ANG_PI) begin
            sc_t1 = sc_th + ANG_TWO_PI;
        end else begin
            sc_t1 = sc_th;
        end
        cnt_eff = (r_wcnt > 4'(WAYPOINTS)) ? 4'(WAYPOINTS) : r_wcnt;
        dx_abs  = (r_dx < 0) ? -r_dx : r_dx;
        dy_abs  = (r_dy < 0) ? -r_dy : r_dy;
        st_p    = r_acc[0][27:0];
        st_l    = STEER_BASE - st_p;
        st_r    = STEER_BASE + st_p;
        st_lc   = (st_l > STEER_LIM) ? STEER_LIM : ((st_l < -STEER_LIM) ? -STEER_LIM : st_l);
        st_rc   = (st_r > STEER_LIM) ? STEER_LIM : ((st_r < -STEER_LIM) ? -STEER_LIM : st_r);
        st_lr   = (st_lc + 28'sd128) >>> 8;
        st_rr   = (st_rc + 28'sd128) >>> 8;
        tf_t    = (r_acc[0] > TURN_LIM) ? TURN_LIM
                : ((r_acc[0] < -TURN_LIM) ? -TURN_LIM : r_acc[0]);
        tf_r    = (tf_t + HALF_Q16) >>> 16;
        e_abs   = (r_e < 0) ? -r_e : r_e;
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc && i_cmd.mode == MODE_LOAD) begin
            tab_x[i_cmd.wp_slot] <= i_cmd.wp_x;
            tab_y[i_cmd.wp_slot] <= i_cmd.wp_y;
            tab_h[i_cmd.wp_slot] <= i_cmd.wp_heading;
        end
        if (r_state == S_T_RD) begin
            r_tx <= tab_x[r_idx[IDX_W-1:0]];
            r_ty <= tab_y[r_idx[IDX_W-1:0]];
            r_th <= tab_h[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_pvld  <= 1'b0;
            r_rx    <= '0;
            r_ry    <= '0;
            r_rh    <= '0;
            r_idx   <= '0;
            r_dtol  <= 17'd3277;
            r_atol  <= 18'd13107;
            r_ox    <= 18'sd20972;
            r_oy    <= 18'sd14418;
            r_gain  <= 16'd6400;
            r_wcnt  <= 4'd0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_DTOL: r_dtol <= pwdata[16:0];
                    REG_ATOL: r_atol <= pwdata[17:0];
                    REG_OFSX: r_ox   <= pwdata[17:0];
                    REG_OFSY: r_oy   <= pwdata[17:0];
                    REG_GAIN: r_gain <= pwdata[15:0];
                    REG_WCNT: r_wcnt <= pwdata[3:0];
                    default: ;
                endcase
            end
            if (r_ov && o_res.ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            if (r_pvld) begin
                r_acc[r_pdst] <= r_acc[r_pdst] + (r_pneg ? -r_prod : r_prod);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_acc) begin
                        r_mode <= i_cmd.mode;
                        r_px   <= i_cmd.pos_x;
                        r_py   <= i_cmd.pos_y;
                        r_qx   <= i_cmd.quat_x;
                        r_qy   <= i_cmd.quat_y;
                        r_qz   <= i_cmd.quat_z;
                        r_qw   <= i_cmd.quat_w;
                        case (i_cmd.mode)
                            MODE_POSE: begin
                                r_mop   <= MOP_QUAT;
                                r_cnt   <= '0;
                                r_acc   <= '{default: '0};
                                r_state <= S_MUL;
                            end
                            MODE_TICK: r_state <= S_T_CHK;
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_cnt == m_last) begin
                        r_pvld <= 1'b0;
                        unique case (r_mop)
                            MOP_QUAT: r_state <= S_P_YAW;
                            MOP_ROT:  r_state <= S_P_FIN;
                            MOP_DIST: r_state <= S_T_DIST;
                            default:  r_state <= S_T_TFIN;
                        endcase
                    end else begin
                        r_prod <= m_a * m_b;
                        r_pdst <= m_dst;
                        r_pneg <= m_neg;
                        r_pvld <= 1'b1;
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                S_P_YAW: begin
                    if (p_lock_abs >= p_mag) begin
                        r_cz    <= '0;
                        r_state <= S_P_HEAD;
                    end else begin
                        r_cx    <= CW'(p_den);
                        r_cy    <= CW'(p_num);
                        r_state <= S_AT_INIT;
                    end
                end
                S_AT_INIT: begin
                    if (r_cx == 0 && r_cy == 0) begin
                        r_cz    <= '0;
                        r_state <= (r_mode == MODE_POSE) ? S_P_HEAD : S_T_FAR;
                    end else begin
                        if (r_cx < 0) begin
                            r_cz <= (r_cy >= 0) ? ANG_PI : -ANG_PI;
                            r_cx <= -r_cx;
                            r_cy <= -r_cy;
                        end else begin
                            r_cz <= '0;
                        end
                        r_state <= S_AT_NORM;
                    end
                end
                S_AT_NORM: begin
                    if (r_cx < NORM_LIMIT && r_cy < NORM_LIMIT && r_cy > -NORM_LIMIT) begin
                        r_cx <= r_cx <<< 1;
                        r_cy <= r_cy <<< 1;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_AT_ITER;
                    end
                end
                S_AT_ITER: begin
                    if (r_cy > 0) begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + atan_val(r_i);
                    end else begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - atan_val(r_i);
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == LAST_STEP) begin
                        r_state <= (r_mode == MODE_POSE) ? S_P_HEAD : S_T_FAR;
                    end
                end
                S_P_HEAD: begin
                    r_rh    <= 20'(r_cz + ANG_HALF_PI);
                    r_state <= S_SC_INIT;
                end
                S_SC_INIT: begin
                    if (sc_t1 > ANG_HALF_PI) begin
                        r_cz   <= sc_t1 - ANG_PI;
                        r_flip <= 1'b1;
                    end else if (sc_t1 < -ANG_HALF_PI) begin
                        r_cz   <= sc_t1 + ANG_PI;
                        r_flip <= 1'b1;
                    end else begin
                        r_cz   <= sc_t1;
                        r_flip <= 1'b0;
                    end
                    r_cx    <= GAIN_INV;
                    r_cy    <= '0;
                    r_i     <= '0;
                    r_state <= S_SC_ITER;
                end
                S_SC_ITER: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - ys;
                        r_cy <= r_cy + xs;
                        r_cz <= r_cz - atan_val(r_i);
                    end else begin
                        r_cx <= r_cx + ys;
                        r_cy <= r_cy - xs;
                        r_cz <= r_cz + atan_val(r_i);
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == LAST_STEP) begin
                        r_state <= S_SC_DONE;
                    end
                end
                S_SC_DONE: begin
                    r_c     <= r_flip ? -r_cx[17:0] : r_cx[17:0];
                    r_s     <= r_flip ? -r_cy[17:0] : r_cy[17:0];
                    r_mop   <= MOP_ROT;
                    r_cnt   <= '0;
                    r_acc   <= '{default: '0};
                    r_state <= S_MUL;
                end
                S_P_FIN: begin
                    r_rx    <= pf_x[31:0];
                    r_ry    <= pf_y[31:0];
                    r_state <= S_IDLE;
                end
                S_T_CHK: begin
                    if (r_idx >= cnt_eff) begin
                        r_l     <= '0;
                        r_r     <= '0;
                        r_ph    <= PH_DONE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_T_RD;
                    end
                end
                S_T_RD: r_state <= S_T_D;
                S_T_D: begin
                    r_dx    <= 33'(r_tx) - 33'(r_rx);
                    r_dy    <= 33'(r_ty) - 33'(r_ry);
                    r_state <= S_T_D2;
                end
                S_T_D2: begin
                    if (dx_abs >= 33'sd1048576 || dy_abs >= 33'sd1048576) begin
                        r_cx    <= CW'(r_dx);
                        r_cy    <= CW'(r_dy);
                        r_state <= S_AT_INIT;
                    end else begin
                        r_mop   <= MOP_DIST;
                        r_cnt   <= '0;
                        r_acc   <= '{default: '0};
                        r_state <= S_MUL;
                    end
                end
                S_T_DIST: begin
                    if (r_acc[0] > r_acc[1]) begin
                        r_cx    <= CW'(r_dx);
                        r_cy    <= CW'(r_dy);
                        r_state <= S_AT_INIT;
                    end else begin
                        r_e     <= ZW'(r_th) - ZW'(r_rh);
                        r_near  <= 1'b1;
                        r_state <= S_NORM;
                    end
                end
                S_T_FAR: begin
                    r_e     <= r_cz - ZW'(r_rh);
                    r_near  <= 1'b0;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (r_e > ANG_PI) begin
                        r_e <= r_e - ANG_TWO_PI;
                    end else if (r_e < -ANG_PI) begin
                        r_e <= r_e + ANG_TWO_PI;
                    end else begin
                        r_state <= r_near ? S_T_TURN : S_T_ST1;
                    end
                end
                S_T_ST1: begin
                    r_acc[0] <= AW'((r_e <<< 5) - (r_e <<< 1));
                    r_state  <= S_T_ST2;
                end
                S_T_ST2: begin
                    r_l     <= st_lr[14:0];
                    r_r     <= st_rr[14:0];
                    r_ph    <= PH_APPROACH;
                    r_state <= S_OUT;
                end
                S_T_TURN: begin
                    if (e_abs > ZW'(r_atol)) begin
                        r_mop   <= MOP_TURN;
                        r_cnt   <= '0;
                        r_acc   <= '{default: '0};
                        r_state <= S_MUL;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_l     <= '0;
                        r_r     <= '0;
                        r_ph    <= PH_REACHED;
                        r_state <= S_OUT;
                    end
                end
                S_T_TFIN: begin
                    r_r     <= tf_r[14:0];
                    r_l     <= -tf_r[14:0];
                    r_ph    <= PH_TURN;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov    <= 1'b1;
                        r_ol    <= r_l;
                        r_or    <= r_r;
                        r_oi    <= r_idx;
                        r_oph   <= r_ph;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[design/wsc_checker.sv]
// Port-level checks of the waypoint steering controller result channel.
module wsc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic signed [14:0] i_left,
    input logic signed [14:0] i_right,
    input logic [3:0]         i_index,
    input logic [1:0]         i_phase
);
    import wsc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_left) && $stable(i_right)
            && $stable(i_index) && $stable(i_phase))
        else $error("result changed while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_phase == PH_REACHED || i_phase == PH_DONE)
            |-> i_left == 15'sd0 && i_right == 15'sd0)
        else $error("nonzero drive when stopped");

    a_spin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_phase == PH_TURN |-> 15'(i_left + i_right) == 15'd0)
        else $error("turn in place drives not opposite");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_index <= 4'(WAYPOINTS))
        else $error("target index beyond table");

endmodule

bind waypoint_steering_controller_core wsc_checker u_wsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_left  (o_res.left_drive),
    .i_right (o_res.right_drive),
    .i_index (o_res.target_index),
    .i_phase (o_res.phase)
);

[bench/wsc_checker.sv]
// Scoreboard for the waypoint steering controller: pose and steering predictor plus result compare.
module wsc_scoreboard
    import wsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsc_cmd_if          cmd,
    wsc_res_if          res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [14:0] left_drive;
        logic signed [14:0] right_drive;
        logic [3:0]         target_index;
        logic [1:0]         phase;
    } drive_t;

    localparam longint PI_Q    = 205887;
    localparam longint HALF_Q  = 102944;
    localparam longint TWOPI_Q = 411775;
    localparam longint GAIN_Q  = 39797;
    localparam longint NLIM    = 64'sd1 << 40;

    longint arctan_q [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                              128, 64, 32, 16, 8, 4, 2, 1};

    logic signed [31:0] wp_x_tbl [WAYPOINTS];
    logic signed [31:0] wp_y_tbl [WAYPOINTS];
    logic signed [19:0] wp_h_tbl [WAYPOINTS];
    logic signed [31:0] pose_x, pose_y;
    logic signed [19:0] pose_h;
    logic [3:0]         target;
    logic [16:0]        dist_tol;
    logic [17:0]        ang_tol;
    logic signed [17:0] cam_x, cam_y;
    logic [15:0]        turn_gain;
    logic [3:0]         wp_count;
    drive_t             drive_q [$];

    function automatic longint iabs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint lim(longint v, longint l);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic longint wrap_angle(longint a);
        while (a > PI_Q) a -= TWOPI_Q;
        while (a < -PI_Q) a += TWOPI_Q;
        return a;
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q : -PI_Q;
            x = -x;
            y = -y;
        end
        while (x < NLIM && iabs64(y) < NLIM) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < 17; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += arctan_q[i];
            end else begin
                x -= ys; y += xs; z -= arctan_q[i];
            end
        end
        return z;
    endfunction

    task automatic rotate(input longint theta, output longint c, output longint s);
        longint x, y, z, xs, ys;
        bit flip;
        x = GAIN_Q;
        y = 0;
        z = wrap_angle(theta);
        flip = 0;
        if (z > HALF_Q) begin
            z -= PI_Q; flip = 1;
        end else if (z < -HALF_Q) begin
            z += PI_Q; flip = 1;
        end
        for (int i = 0; i < 17; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= arctan_q[i];
            end else begin
                x += ys; y -= xs; z += arctan_q[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic update_pose();
        longint qx, qy, qz, qw, ox, oy, num, den, mag, lock, yaw, c, s, xc, yc;
        logic signed [19:0] h;
        logic signed [31:0] nx, ny;
        qx = cmd.quat_x; qy = cmd.quat_y; qz = cmd.quat_z; qw = cmd.quat_w;
        ox = cam_x; oy = cam_y;
        num = 2 * (qx * qy + qw * qz);
        den = qw * qw + qx * qx - qy * qy - qz * qz;
        mag = qw * qw + qx * qx + qy * qy + qz * qz;
        lock = 2 * (qx * qz - qw * qy);
        yaw = (iabs64(lock) >= mag) ? 0 : vec_angle(num, den);
        h = 20'(yaw + HALF_Q);
        pose_h = h;
        rotate(longint'(h), c, s);
        xc = ox - longint'(cmd.pos_y);
        yc = longint'(cmd.pos_x) - oy;
        nx = 32'(xc - rnd_shift(ox * c + oy * s, 16));
        ny = 32'(rnd_shift(ox * s - oy * c, 16) - yc);
        pose_x = nx;
        pose_y = ny;
    endtask

    task automatic steer();
        drive_t d;
        longint dx, dy, tol, e, fe, t, l, r;
        int cnt;
        bit far_away;
        l = 0;
        r = 0;
        cnt = (wp_count > WAYPOINTS) ? WAYPOINTS : wp_count;
        if (target >= cnt) begin
            d.phase = PH_DONE;
        end else begin
            dx = longint'(wp_x_tbl[target]) - longint'(pose_x);
            dy = longint'(wp_y_tbl[target]) - longint'(pose_y);
            tol = dist_tol;
            far_away = iabs64(dx) >= (64'sd1 << 20) || iabs64(dy) >= (64'sd1 << 20) ||
                       dx * dx + dy * dy > tol * tol;
            if (far_away) begin
                e = wrap_angle(vec_angle(dy, dx) - longint'(pose_h));
                l = rnd_shift(lim((64'sd50 << 16) - 30 * e, 64'sd60 << 16), 8);
                r = rnd_shift(lim((64'sd50 << 16) + 30 * e, 64'sd60 << 16), 8);
                d.phase = PH_APPROACH;
            end else begin
                fe = wrap_angle(longint'(wp_h_tbl[target]) - longint'(pose_h));
                if (iabs64(fe) > longint'(ang_tol)) begin
                    t = lim(fe * longint'(turn_gain), 64'sd40 << 24);
                    r = rnd_shift(t, 16);
                    l = -r;
                    d.phase = PH_TURN;
                end else begin
                    target = 4'(target + 1);
                    d.phase = PH_REACHED;
                end
            end
        end
        d.left_drive = 15'(l);
        d.right_drive = 15'(r);
        d.target_index = target;
        drive_q.push_back(d);
    endtask

    always @(posedge i_clk) begin
        drive_t exp_d;
        if (!i_rst_n) begin
            pose_x = 0; pose_y = 0; pose_h = 0; target = 0;
            dist_tol = 17'd3277; ang_tol = 18'd13107; cam_x = 18'sd20972;
            cam_y = 18'sd14418; turn_gain = 16'd6400; wp_count = 4'd0;
            drive_q.delete();
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_DTOL: dist_tol = pwdata[16:0];
                    REG_ATOL: ang_tol = pwdata[17:0];
                    REG_OFSX: cam_x = pwdata[17:0];
                    REG_OFSY: cam_y = pwdata[17:0];
                    REG_GAIN: turn_gain = pwdata[15:0];
                    REG_WCNT: wp_count = pwdata[3:0];
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready) begin
                case (cmd.mode)
                    MODE_POSE: update_pose();
                    MODE_TICK: steer();
                    MODE_LOAD: begin
                        wp_x_tbl[cmd.wp_slot] = cmd.wp_x;
                        wp_y_tbl[cmd.wp_slot] = cmd.wp_y;
                        wp_h_tbl[cmd.wp_slot] = cmd.wp_heading;
                    end
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected result L=%0d R=%0d idx=%0d ph=%0d", $time,
                             res.left_drive, res.right_drive, res.target_index, res.phase);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_d = drive_q.pop_front();
                    if (exp_d.left_drive !== res.left_drive ||
                        exp_d.right_drive !== res.right_drive ||
                        exp_d.target_index !== res.target_index ||
                        exp_d.phase !== res.phase) begin
                        $display("%0t: mismatch exp L=%0d R=%0d idx=%0d ph=%0d got L=%0d R=%0d idx=%0d ph=%0d",
                                 $time, exp_d.left_drive, exp_d.right_drive,
                                 exp_d.target_index, exp_d.phase, res.left_drive,
                                 res.right_drive, res.target_index, res.phase);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= drive_q.size();
    end

endmodule

[bench/testbench.sv]
// Stimulus, flow control and verdict for the waypoint steering controller.
module testbench;
    import wsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata, prdata;
    int                 errors, pending;
    bit                 quiet, long_hold;
    int                 gap_rate;
    int                 idle_cycles;
    longint             cx, cy;

    wsc_cmd_if cmd ();
    wsc_res_if res ();

    waypoint_steering_controller_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wsc_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cmd(cmd), .res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 0;
    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        res.ready = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                res.ready = 0;
                repeat (400) @(negedge i_clk);
                long_hold = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res.ready = 0;
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
            end else begin
                res.ready = 1;
            end
        end
    end

    task automatic send(input logic [1:0] m, input logic [31:0] px, input logic [31:0] py,
                        input logic [17:0] qx, input logic [17:0] qy, input logic [17:0] qz,
                        input logic [17:0] qw, input logic [2:0] slot, input logic [31:0] wx,
                        input logic [31:0] wy, input logic [19:0] wh);
        if (!quiet && gap_rate != 0 && $urandom_range(0, gap_rate) == 0) begin
            @(negedge i_clk);
            cmd.valid = 0;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd.valid = 1;
        cmd.mode = m; cmd.pos_x = px; cmd.pos_y = py;
        cmd.quat_x = qx; cmd.quat_y = qy; cmd.quat_z = qz; cmd.quat_w = qw;
        cmd.wp_slot = slot; cmd.wp_x = wx; cmd.wp_y = wy; cmd.wp_heading = wh;
        @(posedge i_clk);
        while (!cmd.ready) @(posedge i_clk);
    endtask

    task automatic tick();
        send(MODE_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic pose_at(input longint rx, input longint ry, input real ang);
        longint qw, qz;
        qw = longint'($cos(ang / 2.0) * 65536.0);
        qz = longint'($sin(ang / 2.0) * 65536.0);
        send(MODE_POSE, -ry, -rx, 0, 0, qz, qw, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic settle();
        @(negedge i_clk);
        cmd.valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    function automatic longint jitter(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic real rand_ang();
        return (real'($urandom_range(0, 100000)) / 100000.0 - 0.5) * 6.2831853;
    endfunction

    task automatic run_phase(input int items, input bit pressure);
        int k;
        cx = jitter(1 << 22);
        cy = jitter(1 << 22);
        for (int s = 0; s < WAYPOINTS; s++)
            send(MODE_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 s, cx + jitter(40000), cy + jitter(40000), jitter(411775));
        for (int n = 0; n < items; n++) begin
            if (n % 50 == 0) gap_rate = $urandom_range(0, 3) * 2;
            if (pressure && n == items / 2) begin
                long_hold = 1;
                repeat (12) tick();
                settle();
            end
            k = $urandom_range(0, 99);
            if (k < 45) tick();
            else if (k < 75) pose_at(cx + jitter(50000), cy + jitter(50000), rand_ang());
            else if (k < 85)
                send(MODE_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, cx + jitter(40000), cy + jitter(40000), jitter(411775));
            else if (k < 90) pose_at(jitter(1 << 30), jitter(1 << 30), rand_ang());
            else
                send($urandom, $urandom, $urandom, $urandom_range(0, 131072) - 65536,
                     $urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                     $urandom_range(0, 131072) - 65536, $urandom, $urandom, $urandom,
                     jitter(411775));
        end
        settle();
    endtask

    task automatic configure(input int dt, input int at, input int ox, input int oy,
                             input int g, input int wc);
        reg_write(REG_DTOL, dt);
        reg_write(REG_ATOL, at);
        reg_write(REG_OFSX, ox);
        reg_write(REG_OFSY, oy);
        reg_write(REG_GAIN, g);
        reg_write(REG_WCNT, wc);
    endtask

    initial begin
        quiet = 0; long_hold = 0; gap_rate = 3;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        cmd.valid = 0; cmd.mode = MODE_POSE; cmd.pos_x = 0; cmd.pos_y = 0;
        cmd.quat_x = 0; cmd.quat_y = 0; cmd.quat_z = 0; cmd.quat_w = 0;
        cmd.wp_slot = 0; cmd.wp_x = 0; cmd.wp_y = 0; cmd.wp_heading = 0;
        i_rst_n = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;

        // directed: field extremes, gimbal lock, zero quaternion, unused mode, all done
        send(MODE_LOAD, 0, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 411775);
        send(MODE_LOAD, 0, 0, 0, 0, 0, 0, 7, 32'h80000000, 32'h7fffffff, -411775);
        for (int s = 1; s < 7; s++)
            send(MODE_LOAD, 0, 0, 0, 0, 0, 0, s, jitter(100000), jitter(100000), 0);
        tick();
        send(MODE_POSE, 32'h7fffffff, 32'h80000000, 65536, 0, 0, 0, 0, 0, 0, 0);
        send(MODE_POSE, 32'h80000000, 32'h7fffffff, -65536, -65536, -65536, -65536,
             0, 0, 0, 0);
        send(MODE_POSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(MODE_POSE, 0, 0, 46341, 0, 46341, 0, 0, 0, 0, 0);
        send(MODE_NOP, 32'hffffffff, 32'hffffffff, -1, -1, -1, -1, 7, -1, -1, -1);
        tick();
        settle();
        configure(65536, 205887, 0, 0, 65535, 1);
        pose_at(0, 0, 0.0);
        tick();
        send(MODE_LOAD, 0, 0, 0, 0, 0, 0, 0, 1000, -1000, 102944);
        tick();
        pose_at(0, 0, 0.0);
        tick();
        tick();
        settle();

        configure(0, 0, -65536, 65536, 0, 2);
        run_phase(300, 0);
        configure(20000, 3000, 0, 0, 30000, 3);
        run_phase(350, 1);
        configure(65536, 13107, 65536, -65536, 65535, 5);
        run_phase(350, 0);
        configure($urandom_range(0, 65536), $urandom_range(0, 20000),
                  $urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                  $urandom_range(0, 65535), 15);
        run_phase(350, 0);
        configure(40000, 6000, 0, 0, 6400, 8);
        quiet = 1;
        run_phase(400, 0);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[waypoint_steering_controller_core.f]
design/wsc_pkg.sv
design/wsc_cmd_if.sv
design/waypoint_steering_controller_core.sv
design/wsc_checker.sv
bench/wsc_checker.sv
bench/testbench.sv
